// File: hdl/xkpa_pkg.sv
package xkpa_pkg;

  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] second_deriv_density;
    logic signed [IN_W-1:0] rr_term;
    logic signed [IN_W-1:0] sr_term;
    logic signed [IN_W-1:0] ss_term;
    logic signed [IN_W-1:0] s_term;
    logic signed [IN_W-1:0] grad_x;
    logic signed [IN_W-1:0] grad_y;
    logic signed [IN_W-1:0] grad_z;
    logic signed [IN_W-1:0] vec_0;
    logic signed [IN_W-1:0] vec_1;
    logic signed [IN_W-1:0] vec_2;
    logic signed [IN_W-1:0] vec_3;
  } xkpa_point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_0;
    logic signed [OUT_W-1:0] out_1;
    logic signed [OUT_W-1:0] out_2;
    logic signed [OUT_W-1:0] out_3;
    logic                    saturated;
  } xkpa_result_t;

endpackage

// File: hdl/xkpa_if.sv
interface xkpa_point_if import xkpa_pkg::*; ();
  logic        valid;
  logic        ready;
  xkpa_point_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface xkpa_result_if import xkpa_pkg::*; ();
  logic         valid;
  logic         ready;
  xkpa_result_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: hdl/xc_kernel_point_apply.sv
// Per-point exchange-correlation kernel applier.
// point (sink): one grid point per beat, kernel terms, gradient and the
//   real 4-vector z; a complex z is sent as a real beat and an imaginary beat.
// result (source): kernel row 0..3 times z, halved, rounded to nearest and
//   clipped to 32 bits; saturated marks any clipped row.
// cfg_we/cfg_wdata: gradient_mode, 0 uses A = second_deriv_density on z0
//   only, 1 the full 4x4 kernel. Write it only while the pipe is empty.
// Throughput: one beat per cycle while result is not stalled. A beat taken
//   passes six register stages before it is presented on result: products,
//   g.z sum and split products, wide partial products, partial-product
//   merge, row sums, round/saturate into the output register.
// Stall: the whole pipe holds while result is valid and not taken; point.ready
//   follows that, so bubbles pass through and nothing is dropped or repeated.
// Reset (rst, synchronous): clears all stage valid bits and gradient_mode.
module xc_kernel_point_apply import xkpa_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  xkpa_point_if.sink        point,
  xkpa_result_if.source     result
);

  localparam int F       = FRACTION_BITS;
  localparam int P_W     = 2 * IN_W;
  localparam int AM_W    = IN_W + 1;
  localparam int AZ_W    = AM_W + IN_W;
  localparam int SL_W    = IN_W + 1;
  localparam int GZ_W    = P_W + 2;
  localparam int GL_W    = GZ_W / 2;
  localparam int GH_W    = GZ_W - GL_W;
  localparam int SZ0_W   = P_W + IN_W;
  localparam int SRGZ_W  = IN_W + GZ_W;
  localparam int SSGGZ_W = P_W + GZ_W;
  localparam int M1      = (SSGGZ_W > SZ0_W + F) ? SSGGZ_W : SZ0_W + F;
  localparam int M2      = (M1 > P_W + 2 * F) ? M1 : P_W + 2 * F;
  localparam int M3      = (M2 > SRGZ_W) ? M2 : SRGZ_W;
  localparam int M4      = (M3 > AZ_W + F) ? M3 : AZ_W + F;
  localparam int ACC_W   = M4 + 2;
  localparam int SH2     = 2 * F + 1;
  localparam int SH3     = 3 * F + 1;
  localparam int SH4     = 4 * F + 1;
  localparam logic signed [ACC_W-1:0] HALF2 = ACC_W'(1) <<< (SH2 - 1);
  localparam logic signed [ACC_W-1:0] HALF3 = ACC_W'(1) <<< (SH3 - 1);
  localparam logic signed [ACC_W-1:0] HALF4 = ACC_W'(1) <<< (SH4 - 1);

  logic gradient_mode;
  logic adv;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [IN_W-1:0] g_in [3];
  logic signed [IN_W-1:0] zr_in [3];

  // stage 1
  logic signed [AM_W-1:0]  amat1;
  logic signed [P_W-1:0]   dz1;
  logic signed [P_W-1:0]   pgz1 [3];
  logic signed [P_W-1:0]   srg1 [3];
  logic signed [P_W-1:0]   ssg1 [3];
  logic signed [P_W-1:0]   sz1 [3];
  logic signed [IN_W-1:0]  z0_1;
  logic signed [IN_W-1:0]  sr1;

  // stage 2
  logic signed [GZ_W-1:0]       gz2;
  logic signed [AZ_W-1:0]       az2;
  logic signed [P_W-1:0]        dz2;
  logic signed [P_W-1:0]        srgh2 [3];
  logic signed [SL_W+IN_W-1:0]  srgl2 [3];
  logic signed [P_W-1:0]        ssg2 [3];
  logic signed [P_W-1:0]        sz2 [3];
  logic signed [IN_W-1:0]       sr2;

  logic signed [GH_W-1:0]   gh2;
  logic signed [GL_W:0]     gl2;
  logic signed [IN_W-1:0]   ssh2 [3];
  logic signed [SL_W-1:0]   ssl2 [3];

  // stage 3
  logic signed [AZ_W-1:0]          az3;
  logic signed [P_W-1:0]           dz3;
  logic signed [SZ0_W-1:0]         srgz0_3 [3];
  logic signed [IN_W+GH_W-1:0]     srgzh3;
  logic signed [IN_W+GL_W:0]       srgzl3;
  logic signed [IN_W+GH_W-1:0]     phh3 [3];
  logic signed [IN_W+GL_W:0]       phl3 [3];
  logic signed [SL_W+GH_W-1:0]     plh3 [3];
  logic signed [SL_W+GL_W:0]       pll3 [3];
  logic signed [P_W-1:0]           sz3 [3];

  // stage 4
  logic signed [AZ_W-1:0]     az4;
  logic signed [P_W-1:0]      dz4;
  logic signed [SZ0_W-1:0]    srgz0_4 [3];
  logic signed [SRGZ_W-1:0]   srgz4;
  logic signed [SSGGZ_W-1:0]  ssggz4 [3];
  logic signed [P_W-1:0]      sz4 [3];

  // stage 5
  logic signed [ACC_W-1:0] acc5 [4];

  // stage 6 (output register)
  logic signed [ACC_W-1:0] rnd [4];
  logic signed [ACC_W-1:0] shf [4];
  logic                    fits [4];
  logic [OUT_W-1:0]        clip [4];
  xkpa_result_t            res_q;

  assign adv          = !v6 || result.ready;
  assign point.ready  = adv;
  assign result.valid = v6;
  assign result.data  = res_q;

  assign g_in[0]  = point.data.grad_x;
  assign g_in[1]  = point.data.grad_y;
  assign g_in[2]  = point.data.grad_z;
  assign zr_in[0] = point.data.vec_1;
  assign zr_in[1] = point.data.vec_2;
  assign zr_in[2] = point.data.vec_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_mode <= 1'b0;
    end else if (cfg_we) begin
      gradient_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= point.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // split g.z and ss*g_a into signed high / unsigned low halves
  always_comb begin
    gh2 = $signed(gz2[GZ_W-1:GL_W]);
    gl2 = $signed({1'b0, gz2[GL_W-1:0]});
    for (int a = 0; a < 3; a++) begin
      ssh2[a] = $signed(ssg2[a][P_W-1:IN_W]);
      ssl2[a] = $signed({1'b0, ssg2[a][IN_W-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: primary products
      amat1 <= AM_W'(point.data.second_deriv_density) + AM_W'(point.data.rr_term);
      dz1   <= point.data.second_deriv_density * point.data.vec_0;
      z0_1  <= point.data.vec_0;
      sr1   <= point.data.sr_term;
      for (int a = 0; a < 3; a++) begin
        pgz1[a] <= g_in[a] * zr_in[a];
        srg1[a] <= point.data.sr_term * g_in[a];
        ssg1[a] <= point.data.ss_term * g_in[a];
        sz1[a]  <= point.data.s_term * zr_in[a];
      end

      // stage 2: g.z, A*z0, sr*g_a*z0 halves
      gz2 <= GZ_W'(pgz1[0]) + GZ_W'(pgz1[1]) + GZ_W'(pgz1[2]);
      az2 <= amat1 * z0_1;
      dz2 <= dz1;
      sr2 <= sr1;
      for (int a = 0; a < 3; a++) begin
        srgh2[a] <= $signed(srg1[a][P_W-1:IN_W]) * z0_1;
        srgl2[a] <= $signed({1'b0, srg1[a][IN_W-1:0]}) * z0_1;
        ssg2[a]  <= ssg1[a];
        sz2[a]   <= sz1[a];
      end

      // stage 3: partial products against g.z
      az3    <= az2;
      dz3    <= dz2;
      srgzh3 <= sr2 * gh2;
      srgzl3 <= sr2 * gl2;
      for (int a = 0; a < 3; a++) begin
        srgz0_3[a] <= (SZ0_W'(srgh2[a]) <<< IN_W) + SZ0_W'(srgl2[a]);
        phh3[a]    <= ssh2[a] * gh2;
        phl3[a]    <= ssh2[a] * gl2;
        plh3[a]    <= ssl2[a] * gh2;
        pll3[a]    <= ssl2[a] * gl2;
        sz3[a]     <= sz2[a];
      end

      // stage 4: merge partial products
      az4   <= az3;
      dz4   <= dz3;
      srgz4 <= (SRGZ_W'(srgzh3) <<< GL_W) + SRGZ_W'(srgzl3);
      for (int a = 0; a < 3; a++) begin
        srgz0_4[a] <= srgz0_3[a];
        sz4[a]     <= sz3[a];
        ssggz4[a]  <= (SSGGZ_W'(phh3[a]) <<< (IN_W + GL_W))
                    + (SSGGZ_W'(phl3[a]) <<< IN_W)
                    + (SSGGZ_W'(plh3[a]) <<< GL_W)
                    + SSGGZ_W'(pll3[a]);
      end

      // stage 5: exact row sums (row 0 at Q.3F or Q.2F, rows 1..3 at Q.4F)
      acc5[0] <= gradient_mode ? (ACC_W'(az4) <<< F) + ACC_W'(srgz4) : ACC_W'(dz4);
      for (int a = 0; a < 3; a++) begin
        acc5[a+1] <= gradient_mode ?
                     (ACC_W'(srgz0_4[a]) <<< F) + (ACC_W'(sz4[a]) <<< (2 * F))
                     + ACC_W'(ssggz4[a]) : '0;
      end

      // stage 6: round, halve, clip
      res_q.out_0     <= clip[0];
      res_q.out_1     <= clip[1];
      res_q.out_2     <= clip[2];
      res_q.out_3     <= clip[3];
      res_q.saturated <= !(fits[0] && fits[1] && fits[2] && fits[3]);
    end
  end

  // the halving is folded into the final shift (one extra bit)
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (r == 0) begin
        rnd[r] = acc5[r] + (gradient_mode ? HALF3 : HALF2);
        shf[r] = gradient_mode ? (rnd[r] >>> SH3) : (rnd[r] >>> SH2);
      end else begin
        rnd[r] = acc5[r] + HALF4;
        shf[r] = rnd[r] >>> SH4;
      end
      fits[r] = (&shf[r][ACC_W-1:OUT_W-1]) || !(|shf[r][ACC_W-1:OUT_W-1]);
      if (fits[r]) begin
        clip[r] = shf[r][OUT_W-1:0];
      end else if (shf[r][ACC_W-1]) begin
        clip[r] = SAT_MIN;
      end else begin
        clip[r] = SAT_MAX;
      end
    end
  end

endmodule

// File: tb/sv/tb_xc_kernel_point_apply.sv
`timescale 1ns / 1ps

module tb_xc_kernel_point_apply;
  import xkpa_pkg::*;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam logic signed [IN_W-1:0] Q_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] Q_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] Q_ONE = IN_W'(1 <<< FRAC);
  localparam logic MODE_LOCAL = 1'b0;
  localparam logic MODE_GRADIENT = 1'b1;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  xkpa_point_if  point_bus();
  xkpa_result_if result_bus();

  xc_kernel_point_apply #(.FRACTION_BITS(FRAC)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .point    (point_bus),
    .result   (result_bus)
  );

  xkpa_result_t pending_rows[$];
  logic grad_mode;
  int mismatches;
  int quiet_cycles;
  int hold_left;
  int hold_req;
  int hold_seen;
  bit send_steady;
  bit recv_steady;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Round half up after dropping sh fraction bits, then clip to 32 bits.
  function automatic logic signed [OUT_W-1:0] halve_round_clip(
      input logic signed [127:0] acc, input int sh, inout logic clipped);
    logic signed [127:0] one;
    logic signed [127:0] r;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    one = 1;
    hi_lim = SAT_MAX;
    lo_lim = SAT_MIN;
    r = (acc + (one <<< (sh - 1))) >>> sh;
    if (r > hi_lim) begin
      clipped = 1'b1;
      return SAT_MAX;
    end
    if (r < lo_lim) begin
      clipped = 1'b1;
      return SAT_MIN;
    end
    return r[OUT_W-1:0];
  endfunction

  function automatic xkpa_result_t predict_rows(input xkpa_point_t p, input logic mode);
    logic signed [127:0] dmu, rr, sr, ss, s, amat, gdot, row;
    logic signed [127:0] g [3];
    logic signed [127:0] z [4];
    logic signed [OUT_W-1:0] rows [4];
    logic clipped;
    xkpa_result_t res;
    clipped = 1'b0;
    dmu = $signed(p.second_deriv_density);
    rr = $signed(p.rr_term);
    sr = $signed(p.sr_term);
    ss = $signed(p.ss_term);
    s = $signed(p.s_term);
    g[0] = $signed(p.grad_x);
    g[1] = $signed(p.grad_y);
    g[2] = $signed(p.grad_z);
    z[0] = $signed(p.vec_0);
    z[1] = $signed(p.vec_1);
    z[2] = $signed(p.vec_2);
    z[3] = $signed(p.vec_3);
    if (mode == MODE_LOCAL) begin
      rows[0] = halve_round_clip(dmu * z[0], 2 * FRAC + 1, clipped);
      for (int a = 1; a < 4; a++) rows[a] = '0;
    end else begin
      amat = dmu + rr;
      gdot = g[0] * z[1] + g[1] * z[2] + g[2] * z[3];
      // row 0 lives at 3F fraction bits, rows 1..3 at 4F
      rows[0] = halve_round_clip(((amat * z[0]) <<< FRAC) + sr * gdot, 3 * FRAC + 1, clipped);
      for (int a = 0; a < 3; a++) begin
        row = ((sr * g[a] * z[0]) <<< FRAC) + ((s * z[a+1]) <<< (2 * FRAC))
            + ss * g[a] * gdot;
        rows[a+1] = halve_round_clip(row, 4 * FRAC + 1, clipped);
      end
    end
    res.out_0 = rows[0];
    res.out_1 = rows[1];
    res.out_2 = rows[2];
    res.out_3 = rows[3];
    res.saturated = clipped;
    return res;
  endfunction

  function automatic xkpa_point_t make_point(
      input logic signed [IN_W-1:0] d, rr, sr, ss, s, gx, gy, gz, z0, z1, z2, z3);
    xkpa_point_t p;
    p.second_deriv_density = d;
    p.rr_term = rr;
    p.sr_term = sr;
    p.ss_term = ss;
    p.s_term = s;
    p.grad_x = gx;
    p.grad_y = gy;
    p.grad_z = gz;
    p.vec_0 = z0;
    p.vec_1 = z1;
    p.vec_2 = z2;
    p.vec_3 = z3;
    return p;
  endfunction

  function automatic logic signed [IN_W-1:0] rand_term();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4: return IN_W'($signed(raw[18:0]));
      default: return raw[IN_W-1:0];
    endcase
  endfunction

  function automatic xkpa_point_t rand_point();
    return make_point(rand_term(), rand_term(), rand_term(), rand_term(), rand_term(),
                      rand_term(), rand_term(), rand_term(), rand_term(), rand_term(),
                      rand_term(), rand_term());
  endfunction

  task automatic send_point(input xkpa_point_t p);
    @(negedge clk);
    while (!send_steady && $urandom_range(99) < 34) begin
      point_bus.valid = 1'b0;
      @(negedge clk);
    end
    point_bus.valid = 1'b1;
    point_bus.data = p;
    do @(posedge clk); while (point_bus.ready !== 1'b1);
    pending_rows.push_back(predict_rows(p, grad_mode));
  endtask

  task automatic drain_points();
    @(negedge clk);
    point_bus.valid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    drain_points();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = mode;
    grad_mode = mode;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_local_directed();
    xkpa_point_t p;
    send_point(make_point('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_point(make_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                          Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_point(make_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    // gradient inputs must be ignored here
    send_point(make_point(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                          Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    // exact half LSB: +0.5 rounds up, -0.5 rounds toward plus infinity
    send_point(make_point(Q_ONE, '0, '0, '0, '0, '0, '0, '0, Q_ONE, '0, '0, '0));
    send_point(make_point(-Q_ONE, '0, '0, '0, '0, '0, '0, '0, Q_ONE, '0, '0, '0));
    // complex z: real beat then imaginary beat over the same kernel
    p = make_point(24'sh018000, '0, '0, '0, '0, '0, '0, '0, 24'sh020000, '0, '0, '0);
    send_point(p);
    p.vec_0 = -24'sh00C000;
    send_point(p);
  endtask

  task automatic test_gradient_directed();
    xkpa_point_t p;
    set_mode(MODE_GRADIENT);
    send_point(make_point('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_point(make_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                          Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_point(make_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_point(make_point(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                          Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    // diagonal only: s * z_a on rows 1..3
    send_point(make_point(Q_ONE, '0, '0, '0, Q_ONE, '0, '0, '0,
                          Q_ONE, IN_W'(2 * Q_ONE), IN_W'(3 * Q_ONE), IN_W'(4 * Q_ONE)));
    // sigma-rho cross terms only
    send_point(make_point('0, '0, Q_ONE, '0, '0, Q_ONE, -Q_ONE, IN_W'(2 * Q_ONE),
                          Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    // sigma-sigma outer product dominates
    send_point(make_point('0, '0, '0, Q_MAX, '0, Q_MAX, Q_MAX, Q_MAX,
                          '0, Q_MIN, Q_MIN, Q_MIN));
    send_point(make_point(Q_ONE, '0, '0, '0, '0, '0, '0, '0, Q_ONE, '0, '0, '0));
    send_point(make_point('0, -Q_ONE, '0, '0, '0, '0, '0, '0, Q_ONE, '0, '0, '0));
    p = make_point(24'sh00C000, 24'sh004000, -24'sh002000, 24'sh001000, 24'sh030000,
                   24'sh010000, -24'sh008000, 24'sh020000,
                   24'sh010000, -24'sh020000, 24'sh008000, 24'sh001000);
    send_point(p);
    p.vec_0 = 24'sh000800;
    p.vec_1 = 24'sh018000;
    p.vec_2 = -24'sh010000;
    p.vec_3 = -24'sh004000;
    send_point(p);
  endtask

  task automatic test_random_points(input logic mode, input int count);
    xkpa_point_t p;
    int sent;
    set_mode(mode);
    sent = 0;
    while (sent < count) begin
      p = rand_point();
      send_point(p);
      sent++;
      // second half of a complex vector over the same kernel
      if ($urandom_range(3) == 0) begin
        p.vec_0 = rand_term();
        p.vec_1 = rand_term();
        p.vec_2 = rand_term();
        p.vec_3 = rand_term();
        send_point(p);
        sent++;
      end
    end
  endtask

  task automatic test_stall_fill();
    set_mode(MODE_GRADIENT);
    @(posedge clk);
    hold_req = hold_req + 1;
    send_steady = 1'b1;
    repeat (40) send_point(rand_point());
    send_steady = 1'b0;
  endtask

  task automatic test_steady_stream();
    set_mode(MODE_LOCAL);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    repeat (100) send_point(rand_point());
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      result_bus.ready = 1'b0;
      hold_left = hold_left - 1;
    end else if (recv_steady) begin
      result_bus.ready = 1'b1;
    end else begin
      result_bus.ready = ($urandom_range(99) >= 34);
    end
  end

  task automatic check_field(input string name, input logic signed [OUT_W-1:0] want,
                             input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    xkpa_result_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, result_bus.data);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        check_field("out_0", want.out_0, result_bus.data.out_0);
        check_field("out_1", want.out_1, result_bus.data.out_1);
        check_field("out_2", want.out_2, result_bus.data.out_2);
        check_field("out_3", want.out_3, result_bus.data.out_3);
        check_field("saturated", OUT_W'(want.saturated),
                    OUT_W'(result_bus.data.saturated));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (point_bus.valid && point_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    point_bus.valid = 1'b0;
    point_bus.data = '0;
    grad_mode = MODE_LOCAL;
    hold_req = 0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_local_directed();
    test_gradient_directed();
    test_random_points(MODE_LOCAL, 150);
    test_random_points(MODE_GRADIENT, 250);
    test_stall_fill();
    test_steady_stream();
    test_random_points(MODE_GRADIENT, 300);
    test_random_points(MODE_LOCAL, 60);

    drain_points();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
